[rtl/prs_pkg.sv]
// Package for the polyphase resampler: filter sizes, word widths and the
// payload structs of the sample and result channels. No dependencies.
package prs_pkg;

    localparam int PHASES      = 256;
    localparam int TAPS        = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_OUT     = 17;

    localparam int PHASE_BITS = $clog2(PHASES);
    localparam int TAP_BITS   = $clog2(TAPS);
    localparam int COEF_AW    = PHASE_BITS + TAP_BITS;
    localparam int HIST_DEPTH = TAPS + 1;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int COEF_BITS  = 24;
    localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_W      = PROD_W + TAP_BITS;
    localparam int ACC_W      = 64;
    localparam int POS_W      = 48;
    localparam int STEP_W     = 25;
    localparam int WOFS_W     = 7;
    localparam int AGE_W      = 33;
    localparam int ISSUE_N    = 2 * TAPS;
    localparam int ISSUE_W    = $clog2(ISSUE_N + 1);
    localparam int CNT_W      = $clog2(MAX_OUT + 1);

    localparam logic CMD_LOAD_COEF = 1'b0;
    localparam logic CMD_PUSH      = 1'b1;

    localparam logic REG_PHASE_STEP    = 1'b0;
    localparam logic REG_WINDOW_OFFSET = 1'b1;

    typedef struct packed {
        logic                          command;
        logic [13:0]                   coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last;
    } out_item_t;

endpackage

[rtl/prs_hist.sv]
// Sample history of the polyphase resampler: a circular buffer read by age.
// Depends on prs_pkg.
module prs_hist (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  push,
    input  logic signed [prs_pkg::SAMPLE_BITS-1:0] push_data,
    input  logic                                  rd_en,
    input  logic [prs_pkg::AGE_W-1:0]             rd_age,
    output logic signed [prs_pkg::SAMPLE_BITS-1:0] rd_data
);
    import prs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [0:(2**HIST_AW)-1];
    logic signed [SAMPLE_BITS-1:0] raw_reg;
    logic [HIST_AW-1:0]            wptr_reg, wptr_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic                          stale_reg, stale_next;
    logic [HIST_AW-1:0]            raddr;

    // Entries not yet pushed since reset read as zero through the fill count.
    assign raddr = wptr_reg - HIST_AW'(1) - rd_age[HIST_AW-1:0];

    always_comb begin
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        stale_next = stale_reg;
        if (push) begin
            wptr_next = wptr_reg + HIST_AW'(1);
            if (fill_reg != FILL_W'(HIST_DEPTH)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (rd_en) begin
            stale_next = (rd_age >= AGE_W'(fill_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
        if (rd_en) begin
            raw_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            fill_reg  <= '0;
            stale_reg <= 1'b1;
        end else begin
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
            stale_reg <= stale_next;
        end
    end

    assign rd_data = stale_reg ? '0 : raw_reg;

endmodule

[rtl/polyphase_resampler.sv]
// Polyphase FIR resampler top level: sequencer, coefficient memory, shared MAC.
// Depends on prs_pkg and prs_hist.
//
// Usage: items arrive on the s_ channel. A load item writes one coefficient
// and leaves s_ready high. A push item stores one sample and then produces
// every output whose window is complete, at most 17, on the m_ channel; the
// final one carries last. Each output runs 128 multiply-accumulates through
// one shared 24x24 multiplier fed by the coefficient memory read port, one
// per cycle, and s_ready stays low after a push transfer until the last
// output of that push has been handed to the output register. A finished
// result waits in a holding register while the next is computed; if the
// receiver stalls, the sequencer waits before handing over the next one.
// Reset clears the history, position, sample count and registers
// (phase_step = 1.0, window_offset = -32); coefficients must be loaded
// before use. The user must write the registers over the APB port only
// while idle; the block itself does not enforce this.
module polyphase_resampler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  prs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output prs_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import prs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVAL, ST_MAC, ST_DIFF, ST_SCALE, ST_ROUND
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [WOFS_W-1:0] wofs_reg, wofs_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [31:0]              rcvd_reg, rcvd_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pend_reg, pend_next;
    logic signed [SAMPLE_BITS-1:0] pend_val_reg, pend_val_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic [PHASE_BITS-1:0]    k0_reg, k0_next, k1_reg, k1_next;
    logic [7:0]               blend_reg, blend_next;
    logic                     shift_reg, shift_next;
    logic [31:0]              d_reg, d_next;
    logic [ISSUE_W-1:0]       issue_reg, issue_next;
    logic                     v1_reg, v1_next, sel1_reg, sel1_next;
    logic                     v2_reg, v2_next, sel2_reg, sel2_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum0_reg, sum0_next, sum1_reg, sum1_next;
    logic signed [SUM_W:0]    diff_reg, diff_next;
    logic signed [ACC_W-1:0]  scaled_reg, scaled_next;

    logic signed [COEF_BITS-1:0] coef_mem [0:(2**COEF_AW)-1];
    logic signed [COEF_BITS-1:0] coef_rd_reg;
    logic [COEF_AW-1:0]          coef_raddr;
    logic signed [SAMPLE_BITS-1:0] hist_rd;
    logic [AGE_W-1:0]            age;
    logic                        issuing;
    logic [TAP_BITS-1:0]         tap;
    logic                        sel;

    logic in_xfer, load_xfer, push_xfer, cfg_wr, out_free;
    logic [31:0] wend, lag;
    logic        done_w;
    logic [PHASE_BITS-1:0] k0_w;
    logic signed [ACC_W-1:0] acc, rnd;

    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign load_xfer = in_xfer && (s_data.command == CMD_LOAD_COEF);
    assign push_xfer = in_xfer && (s_data.command == CMD_PUSH);
    assign cfg_wr    = psel && penable && pwrite;
    assign out_free  = !m_valid_reg || m_ready;
    assign pready    = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        case (paddr[2])
            REG_PHASE_STEP:    prdata = 32'(step_reg);
            REG_WINDOW_OFFSET: prdata = 32'(wofs_reg);
            default:           prdata = '0;
        endcase
    end

    // Tap issue: even steps feed the phase k0 sum, odd steps the phase k1 sum.
    assign issuing    = (state_reg == ST_MAC) && (issue_reg < ISSUE_W'(ISSUE_N));
    assign tap        = issue_reg[TAP_BITS:1];
    assign sel        = issue_reg[0];
    assign coef_raddr = {sel ? k1_reg : k0_reg, tap};
    assign age        = AGE_W'(d_reg) + AGE_W'(TAPS - 1) - AGE_W'(tap)
                        + AGE_W'((!sel) && shift_reg);

    prs_hist u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_xfer),
        .push_data (s_data.sample_in),
        .rd_en     (issuing),
        .rd_age    (age),
        .rd_data   (hist_rd)
    );

    always_ff @(posedge aclk) begin
        if (load_xfer) begin
            coef_mem[s_data.coef_index[COEF_AW-1:0]] <= s_data.coef_value;
        end
        if (issuing) begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    // Window check: the newest sample the window needs must already be here.
    assign k0_w   = pos_reg[15:8];
    assign wend   = pos_reg[47:16] + 32'(wofs_reg) + 32'(&k0_w) + 32'(TAPS - 1);
    assign lag    = rcvd_reg - 32'd1 - wend;
    assign done_w = lag[31] || (cnt_reg == CNT_W'(MAX_OUT));

    assign acc = (ACC_W'(sum0_reg) <<< 8) + scaled_reg;
    assign rnd = (acc + (ACC_W'(1) <<< 29)) >>> 30;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        wofs_next     = wofs_reg;
        pos_next      = pos_reg;
        rcvd_next     = rcvd_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_val_next = pend_val_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        k0_next       = k0_reg;
        k1_next       = k1_reg;
        blend_next    = blend_reg;
        shift_next    = shift_reg;
        d_next        = d_reg;
        issue_next    = issue_reg;
        v1_next       = issuing;
        sel1_next     = sel;
        v2_next       = v1_reg;
        sel2_next     = sel1_reg;
        prod_next     = PROD_W'(coef_rd_reg) * PROD_W'(hist_rd);
        sum0_next     = sum0_reg;
        sum1_next     = sum1_reg;
        diff_next     = diff_reg;
        scaled_next   = scaled_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_wr) begin
            case (paddr[2])
                REG_PHASE_STEP:    step_next = pwdata[STEP_W-1:0];
                REG_WINDOW_OFFSET: wofs_next = pwdata[WOFS_W-1:0];
                default:           step_next = step_reg;
            endcase
        end
        if (v2_reg) begin
            if (sel2_reg) begin
                sum1_next = sum1_reg + SUM_W'(prod_reg);
            end else begin
                sum0_next = sum0_reg + SUM_W'(prod_reg);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (push_xfer) begin
                    rcvd_next  = rcvd_reg + 32'd1;
                    cnt_next   = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        m_valid_next           = 1'b1;
                        m_data_next.sample_out = pend_val_reg;
                        m_data_next.last       = done_w;
                        pend_next              = 1'b0;
                    end
                    if (done_w) begin
                        state_next = ST_IDLE;
                    end else begin
                        k0_next    = k0_w;
                        k1_next    = k0_w + PHASE_BITS'(1);
                        shift_next = &k0_w;
                        blend_next = pos_reg[7:0];
                        d_next     = lag;
                        issue_next = '0;
                        sum0_next  = '0;
                        sum1_next  = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (issuing) begin
                    issue_next = issue_reg + ISSUE_W'(1);
                end else if (!v1_reg && !v2_reg) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                diff_next  = (SUM_W+1)'(sum1_reg) - (SUM_W+1)'(sum0_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                scaled_next = ACC_W'($signed({1'b0, blend_reg})) * ACC_W'(diff_reg);
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                if (rnd > SMAX) begin
                    pend_val_next = SAMPLE_BITS'(SMAX);
                end else if (rnd < SMIN) begin
                    pend_val_next = SAMPLE_BITS'(SMIN);
                end else begin
                    pend_val_next = SAMPLE_BITS'(rnd);
                end
                pend_next  = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                pos_next   = pos_reg + POS_W'(step_reg);
                state_next = ST_EVAL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_W'(65536);
            wofs_reg    <= -WOFS_W'(32);
            pos_reg     <= '0;
            rcvd_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            issue_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            wofs_reg    <= wofs_next;
            pos_reg     <= pos_next;
            rcvd_reg    <= rcvd_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            issue_reg   <= issue_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
        end
        pend_val_reg <= pend_val_next;
        m_data_reg   <= m_data_next;
        k0_reg       <= k0_next;
        k1_reg       <= k1_next;
        blend_reg    <= blend_next;
        shift_reg    <= shift_next;
        d_reg        <= d_next;
        sel1_reg     <= sel1_next;
        sel2_reg     <= sel2_next;
        prod_reg     <= prod_next;
        sum0_reg     <= sum0_next;
        sum1_reg     <= sum1_next;
        diff_reg     <= diff_next;
        scaled_reg   <= scaled_next;
    end

endmodule

[tb/sv/prs_checker.sv]
// Checker for the polyphase resampler: watches the sample, result and APB ports,
// predicts every result and compares it field by field. Depends on prs_pkg.
`timescale 1ns / 100ps

module prs_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  prs_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  prs_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending
);
    import prs_pkg::*;

    logic signed [23:0] coef_mem [PHASES*TAPS];
    longint             history [HIST_DEPTH];
    logic [47:0]        out_pos;
    logic [31:0]        n_received;
    logic [24:0]        step_reg;
    logic signed [6:0]  wofs_reg;
    out_item_t          resample_q [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic longint hist_at(longint unsigned age);
        if (age < longint'(HIST_DEPTH))
            return history[age];
        return 0;
    endfunction

    // Shift one sample into the history and queue every output it completes.
    task automatic push_sample(logic signed [23:0] smp);
        logic [31:0]    ipart;
        logic [7:0]     k0, k1;
        logic [31:0]    shift, wend, lag;
        longint         blend, sum0, sum1, acc, res;
        longint unsigned a1;
        out_item_t      item;
        int             cnt;
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = longint'(smp);
        n_received = n_received + 32'd1;
        cnt = 0;
        while (cnt < MAX_OUT) begin
            ipart = out_pos[47:16];
            k0    = out_pos[15:8];
            blend = longint'(out_pos[7:0]);
            k1    = k0 + 8'd1;
            shift = (k0 == 8'd255) ? 32'd1 : 32'd0;
            wend  = ipart + 32'($signed(wofs_reg)) + shift + 32'(TAPS - 1);
            lag   = n_received - 32'd1 - wend;
            if (lag[31])
                break;
            sum0 = 0;
            sum1 = 0;
            for (int j = 0; j < TAPS; j++) begin
                a1 = longint'(lag) + longint'(TAPS - 1 - j);
                sum0 += longint'(coef_mem[int'(k0) * TAPS + j]) * hist_at(a1 + shift);
                sum1 += longint'(coef_mem[int'(k1) * TAPS + j]) * hist_at(a1);
            end
            acc = sum0 * 256 + blend * (sum1 - sum0);
            res = (acc + (longint'(1) << 29)) >>> 30;
            if (res > 64'sd8388607)
                res = 64'sd8388607;
            if (res < -64'sd8388608)
                res = -64'sd8388608;
            item.sample_out = res[23:0];
            item.last       = 1'b0;
            resample_q.push_back(item);
            cnt++;
            out_pos = out_pos + 48'(step_reg);
        end
        if (cnt > 0)
            resample_q[resample_q.size()-1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++)
                history[i] = 0;
            out_pos    = '0;
            n_received = '0;
            step_reg   = 25'd65536;
            wofs_reg   = -7'sd32;
            resample_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PHASE_STEP)
                    step_reg = pwdata[24:0];
                else
                    wofs_reg = pwdata[6:0];
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_LOAD_COEF)
                    coef_mem[s_data.coef_index] = s_data.coef_value;
                else
                    push_sample(s_data.sample_in);
            end
            if (m_valid && m_ready) begin
                if (resample_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: sample_out=%0d last=%0b",
                                 $signed(m_data.sample_out), m_data.last);
                end else begin
                    if (m_data.sample_out !== resample_q[0].sample_out
                        || m_data.last !== resample_q[0].last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                     $signed(resample_q[0].sample_out),
                                     resample_q[0].last,
                                     $signed(m_data.sample_out), m_data.last);
                    end
                    void'(resample_q.pop_front());
                end
            end
        end
        pending = resample_q.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the resampler testbench: clock, reset, stimulus, APB writes and the
// verdict. Depends on prs_pkg, prs_checker and the polyphase_resampler RTL.
`timescale 1ns / 100ps

module testbench;
    import prs_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 300;
    // Only phases 0 and 1 are read: every step used below keeps the position
    // fraction under one phase. They are loaded, as is one entry of phase 255.
    localparam int LIVE_COEFS  = 2 * TAPS;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;
    int         errors;
    int         pending;
    int         cycles;
    logic       hold_go;
    logic       calm;

    polyphase_resampler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    prs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [23:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'h7FFFFF;
        if (r == 1)
            return 24'h800000;
        return 24'($urandom());
    endfunction

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int gap;
        m_ready = 1'b0;
        gap = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                m_ready = 1'b0;
                repeat (4000) @(negedge aclk);
                hold_go = 1'b0;
            end
            if (gap > 0) begin
                m_ready = 1'b0;
                gap--;
            end else begin
                m_ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    gap = pick_gap();
            end
        end
    end

    task automatic send(in_item_t item, int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(int idx, logic [23:0] val, int gap);
        in_item_t item;
        item            = '0;
        item.command    = CMD_LOAD_COEF;
        item.coef_index = idx[13:0];
        item.coef_value = val;
        item.sample_in  = 24'($urandom());
        send(item, gap);
    endtask

    task automatic send_push(logic [23:0] smp, int gap);
        in_item_t item;
        item            = '0;
        item.command    = CMD_PUSH;
        item.coef_index = 14'($urandom());
        item.coef_value = 24'($urandom());
        item.sample_in  = smp;
        send(item, gap);
    endtask

    task automatic apb_write(logic addr_sel, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {addr_sel, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic run_phase(logic [24:0] step, logic signed [6:0] wofs, int n_items);
        logic [23:0] cval;
        apb_write(REG_PHASE_STEP, 32'(step));
        apb_write(REG_WINDOW_OFFSET, 32'($unsigned(wofs)));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                cval = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                   : 24'($signed($urandom_range(0, 65535)) - 32768);
                send_load($urandom_range(0, LIVE_COEFS - 1), cval, pick_gap());
            end else begin
                send_push(pick_sample(), pick_gap());
            end
        end
        drain();
    endtask

    initial begin
        logic [23:0] cval;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        hold_go = 1'b0;
        calm    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill the two phases that the stimulus below reads.
        for (int i = 0; i < LIVE_COEFS; i++) begin
            if (i % 29 == 0)
                cval = ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
            else
                cval = 24'($signed($urandom_range(0, 32767)) - 16384);
            send_load(i, cval, ($urandom_range(0, 15) == 0) ? pick_gap() : 0);
        end

        // Directed: extreme coefficients and samples at reset settings. The
        // first window is not complete yet, so these pushes return nothing.
        send_load(0, 24'h7FFFFF, 0);
        send_load(PHASES * TAPS - 1, 24'h800000, 1);
        send_load(TAPS - 1, 24'h000000, 0);
        send_push(24'h7FFFFF, 0);
        send_push(24'h800000, 0);
        send_push(24'h000000, 2);
        send_push(24'hFFFFFF, 0);
        send_push(24'h000001, 0);
        for (int i = 0; i < 3; i++)
            send_push(24'h7FFFFF, 0);
        for (int i = 0; i < 2; i++)
            send_push(24'h800000, 1);
        drain();

        // A step just above one sample moves the blend fraction slowly.
        calm = 1'b1;
        run_phase(25'd65538, -7'sd64, 8);
        calm = 1'b0;
        // Tiny and zero steps hit the per-push output cap on every push, and
        // the windows run past the history.
        run_phase(25'd1, -7'sd64, 3);
        run_phase(25'd0, -7'sd64, 3);
        hold_go = 1'b1;
        run_phase(25'd65536, -7'sd64, 10);
        run_phase(25'(65536 * $urandom_range(1, 2)), 7'($signed($urandom_range(0, 24)) - 64), 8);
        run_phase(25'd16777216, -7'sd64, 4);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
